[hw/rtl/phm_pkg.sv]
// shared types, codes and constants of the parallel io handshake master
// no dependencies; imported by every module of the block
`default_nettype none

package phm_pkg;

  // default transmit buffer depth
  localparam int unsigned FRAME_BYTES_DEF = 256;

  // configuration register indexes and reset values
  localparam logic       CFG_HS_TIMEOUT   = 1'b0;
  localparam logic       CFG_SYNC_RETRIES = 1'b1;
  localparam logic [15:0] HS_TIMEOUT_RST   = 16'd2000;
  localparam logic [7:0]  SYNC_RETRIES_RST = 8'd10;

  // link bytes
  localparam logic [7:0] CMD_RESYNC    = 8'h5a;
  localparam logic [7:0] SYNC_ACK_BYTE = 8'h07;
  localparam logic [7:0] CMD_XFER      = 8'h01;
  localparam logic [7:0] BYTE_NULL     = 8'h00;

  // wait counter saturation
  localparam logic [15:0] WAIT_MAX = 16'hffff;

  // item actions
  localparam logic [2:0] ACT_POLL   = 3'd0;
  localparam logic [2:0] ACT_RESYNC = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_WRITE  = 3'd3;
  localparam logic [2:0] ACT_STORE  = 3'd4;

  // completion status
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_DATA   = 2'd1;
  localparam logic [1:0] STATUS_SYNC_FAIL = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RS_SEND = 4'd1,
    PH_RS_NULL = 4'd2,
    PH_RS_ACK  = 4'd3,
    PH_RS_TAIL = 4'd4,
    PH_RD_LEN  = 4'd5,
    PH_RD_DATA = 4'd6,
    PH_RD_TAIL = 4'd7,
    PH_WR_LEN  = 4'd8,
    PH_WR_DATA = 4'd9,
    PH_WR_END  = 4'd10,
    PH_WR_TAIL = 4'd11
  } phase_e;

  typedef struct packed {
    logic [2:0] action;
    logic       hs_level;
    logic       clock_tick;
    logic [7:0] bus_in;
    logic [7:0] tx_byte;
    logic [7:0] tx_index;
    logic [7:0] write_length;
  } item_t;

  typedef struct packed {
    logic [7:0] bus_out;
    logic       bus_write;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] frame_length;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [15:0] hs_timeout;
    logic [7:0]  sync_retries;
  } cfg_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } buf_wr_t;

endpackage

`default_nettype wire

[hw/rtl/parallel_io_handshake_master_top.sv]
// top level of the parallel io handshake master: stream ports, config registers,
// input and result registers; depends on phm_pkg, phm_txbuf and phm_ctrl
`default_nettype none

// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser action, tdata step fields
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata result fields
// cfg       | in        | cfg_we_i (no back-pressure)   | cfg_addr_i, cfg_wdata_i
//
// one item per cycle sustained while m_axis_tready holds high; an item lands in
// the input register when accepted and its result is registered when the sequencer
// steps; the rate is set by the phase register, which takes one step per item
// rst_ni clears control state and config to 2000 ticks and 10 retries; the
// transmit buffer is not cleared and reads as garbage until stored
// m_axis_tready low holds the result and the input register; s_axis keeps taking
// an item while the input register is empty

module parallel_io_handshake_master_top #(
  parameter int unsigned FRAME_BYTES = phm_pkg::FRAME_BYTES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] hs_level, [1] clock_tick, [9:2] bus_in, [17:10] tx_byte,
  // [25:18] tx_index, [33:26] write_length, [39:34] zero
  input  wire [39:0]  s_axis_tdata,
  // [2:0] action
  input  wire [2:0]   s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] bus_out, [8] bus_write, [16:9] rx_byte, [17] rx_valid,
  // [25:18] rx_index, [33:26] frame_length, [34] done_res, [36:35] status,
  // [37] busy_res, [39:38] zero
  output logic [39:0] m_axis_tdata,
  // configuration writes
  input  wire         cfg_we_i,
  input  wire         cfg_addr_i,
  input  wire [15:0]  cfg_wdata_i
);
  import phm_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  // config registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hs_timeout   <= HS_TIMEOUT_RST;
      cfg_q.sync_retries <= SYNC_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_HS_TIMEOUT:   cfg_q.hs_timeout   <= cfg_wdata_i;
        CFG_SYNC_RETRIES: cfg_q.sync_retries <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control: the step moves when the result register is free
  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    advance, step, in_take;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.action       <= s_axis_tuser;
      in_q.hs_level     <= s_axis_tdata[0];
      in_q.clock_tick   <= s_axis_tdata[1];
      in_q.bus_in       <= s_axis_tdata[9:2];
      in_q.tx_byte      <= s_axis_tdata[17:10];
      in_q.tx_index     <= s_axis_tdata[25:18];
      in_q.write_length <= s_axis_tdata[33:26];
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  // sequencer and transmit buffer
  buf_wr_t       buf_wr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  phm_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_q),
    .cfg_i     (cfg_q),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .buf_wr_o  (buf_wr),
    .res_o     (res_d)
  );

  phm_txbuf #(
    .DEPTH (FRAME_BYTES)
  ) u_txbuf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // result packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.busy_res, res_q.status, res_q.done_res,
                          res_q.frame_length, res_q.rx_index, res_q.rx_valid,
                          res_q.rx_byte, res_q.bus_write, res_q.bus_out};

  // a finished sequence never reports itself as still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.done_res) |-> !res_q.busy_res)
    else $error("done result with busy set");

  // a step never drives the bus and delivers a received byte at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.bus_write && res_q.rx_valid))
    else $error("bus write and rx byte in one result");

  // every step leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("step without a result");

endmodule

`default_nettype wire

[hw/rtl/phm_txbuf.sv]
// transmit byte buffer, one write and one registered read port
// depends on phm_pkg for the write request struct
`default_nettype none

module phm_txbuf #(
  parameter int unsigned DEPTH = phm_pkg::FRAME_BYTES_DEF
) (
  input  wire                      clk_i,
  input  wire phm_pkg::buf_wr_t    wr_i,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr_i,
  output logic [7:0]               rd_data_o
);
  import phm_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/phm_ctrl.sv]
// sequencer: phase register, handshake wait counter and per-item result logic
// depends on phm_pkg; reads the transmit buffer through phm_txbuf
`default_nettype none

module phm_ctrl #(
  parameter int unsigned FRAME_BYTES = phm_pkg::FRAME_BYTES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            step_i,
  input  wire phm_pkg::item_t            item_i,
  input  wire phm_pkg::cfg_t             cfg_i,
  input  wire [7:0]                      rd_data_i,
  output logic [$clog2(FRAME_BYTES)-1:0] rd_addr_o,
  output phm_pkg::buf_wr_t               buf_wr_o,
  output phm_pkg::result_t               res_o
);
  import phm_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam logic [8:0]  FrameLim = 9'(FRAME_BYTES);

  phase_e      phase_q, phase_d;
  logic [15:0] wait_q, wait_d, wait_inc;
  logic [7:0]  retry_q, retry_d, retry_inc;
  logic [7:0]  count_q, count_d, count_inc;
  logic [7:0]  len_q, len_d, wlen_clamped;
  logic        hs_done, retry_fail;

  // handshake wait: count a tick first, then compare
  assign wait_inc   = (item_i.clock_tick && (wait_q != WAIT_MAX)) ? wait_q + 16'd1 : wait_q;
  assign hs_done    = !item_i.hs_level || (wait_inc >= cfg_i.hs_timeout);
  assign retry_inc  = retry_q + 8'd1;
  assign retry_fail = retry_inc >= cfg_i.sync_retries;
  assign count_inc  = count_q + 8'd1;
  assign wlen_clamped = ({1'b0, item_i.write_length} > FrameLim) ? FrameLim[7:0]
                                                                : item_i.write_length;

  // next state
  always_comb begin
    phase_d = phase_q;
    retry_d = retry_q;
    count_d = count_q;
    len_d   = len_q;
    wait_d  = ((phase_q == PH_IDLE) || hs_done) ? 16'd0 : wait_inc;
    case (phase_q)
      PH_RS_SEND: if (hs_done) phase_d = PH_RS_NULL;
      PH_RS_NULL: if (hs_done) phase_d = PH_RS_ACK;
      PH_RS_ACK: begin
        if (hs_done) begin
          if (item_i.bus_in == SYNC_ACK_BYTE) begin
            phase_d = PH_RS_TAIL;
          end else begin
            retry_d = retry_inc;
            phase_d = retry_fail ? PH_IDLE : PH_RS_SEND;
          end
        end
      end
      PH_RS_TAIL: if (hs_done) phase_d = PH_IDLE;
      PH_RD_LEN: begin
        if (hs_done) begin
          len_d   = item_i.bus_in;
          count_d = 8'd0;
          phase_d = (item_i.bus_in == 8'd0) ? PH_RD_TAIL : PH_RD_DATA;
        end
      end
      PH_RD_DATA: begin
        if (hs_done) begin
          count_d = count_inc;
          if (count_inc >= len_q) phase_d = PH_RD_TAIL;
        end
      end
      PH_RD_TAIL: if (hs_done) phase_d = PH_IDLE;
      PH_WR_LEN: begin
        if (hs_done) begin
          count_d = 8'd0;
          phase_d = (len_q == 8'd0) ? PH_WR_END : PH_WR_DATA;
        end
      end
      PH_WR_DATA: begin
        if (hs_done) begin
          count_d = count_inc;
          if (count_inc >= len_q) phase_d = PH_WR_END;
        end
      end
      PH_WR_END:  if (hs_done) phase_d = PH_WR_TAIL;
      PH_WR_TAIL: if (hs_done) phase_d = PH_IDLE;
      default: begin
        phase_d = PH_IDLE;
        case (item_i.action)
          ACT_RESYNC: begin
            retry_d = 8'd0;
            if (cfg_i.sync_retries != 8'd0) phase_d = PH_RS_SEND;
          end
          ACT_READ: begin
            if (!item_i.hs_level && (item_i.bus_in != 8'd0)) begin
              phase_d = PH_RD_LEN;
            end else if (!item_i.hs_level) begin
              len_d   = 8'd0;
              phase_d = PH_RD_TAIL;
            end
          end
          ACT_WRITE: begin
            len_d   = wlen_clamped;
            phase_d = PH_WR_LEN;
          end
          default: ;
        endcase
      end
    endcase
  end

  // result of this item
  always_comb begin
    res_o          = '0;
    res_o.busy_res = (phase_d != PH_IDLE);
    case (phase_q)
      PH_RS_SEND: begin
        if (hs_done) begin
          res_o.bus_out   = CMD_RESYNC;
          res_o.bus_write = 1'b1;
        end
      end
      PH_RS_NULL, PH_WR_END: begin
        if (hs_done) begin
          res_o.bus_out   = BYTE_NULL;
          res_o.bus_write = 1'b1;
        end
      end
      PH_RS_ACK: begin
        if (hs_done && (item_i.bus_in != SYNC_ACK_BYTE) && retry_fail) begin
          res_o.done_res = 1'b1;
          res_o.status   = STATUS_SYNC_FAIL;
        end
      end
      PH_RS_TAIL, PH_WR_TAIL: begin
        if (hs_done) res_o.done_res = 1'b1;
      end
      PH_RD_LEN: ;
      PH_RD_DATA: begin
        if (hs_done) begin
          res_o.rx_byte  = item_i.bus_in;
          res_o.rx_valid = 1'b1;
          res_o.rx_index = count_q;
        end
      end
      PH_RD_TAIL: begin
        if (hs_done) begin
          res_o.done_res     = 1'b1;
          res_o.frame_length = len_q;
          res_o.status       = (len_q == 8'd0) ? STATUS_NO_DATA : STATUS_OK;
        end
      end
      PH_WR_LEN: begin
        if (hs_done) begin
          res_o.bus_out   = len_q;
          res_o.bus_write = 1'b1;
        end
      end
      PH_WR_DATA: begin
        if (hs_done) begin
          res_o.bus_out   = rd_data_i;
          res_o.bus_write = 1'b1;
        end
      end
      default: begin
        case (item_i.action)
          ACT_RESYNC: begin
            if (cfg_i.sync_retries == 8'd0) begin
              res_o.done_res = 1'b1;
              res_o.status   = STATUS_SYNC_FAIL;
            end
          end
          ACT_READ: begin
            if (item_i.hs_level) begin
              res_o.done_res = 1'b1;
              res_o.status   = STATUS_NO_DATA;
            end
          end
          ACT_WRITE: begin
            res_o.bus_out   = CMD_XFER;
            res_o.bus_write = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
  end

  // buffer store while idle, position checked against the depth
  always_comb begin
    buf_wr_o.we   = step_i && (phase_q == PH_IDLE) && (item_i.action == ACT_STORE) &&
                    ({1'b0, item_i.tx_index} < FrameLim);
    buf_wr_o.addr = item_i.tx_index;
    buf_wr_o.data = item_i.tx_byte;
  end

  // read ahead at the count the next item will use
  logic [7:0] count_next;
  assign count_next = step_i ? count_d : count_q;
  assign rd_addr_o  = count_next[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= 16'd0;
      retry_q <= 8'd0;
      count_q <= 8'd0;
      len_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      retry_q <= retry_d;
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire
